// File: src/damped_feedback_echo_assert.svh
// Assertion macros for the damped feedback echo.
// Each macro takes a label, an antecedent, a consequent and a message.
// The enclosing module provides clk and rst.
`ifndef DAMPED_FEEDBACK_ECHO_ASSERT_SVH
`define DAMPED_FEEDBACK_ECHO_ASSERT_SVH

`ifndef SYNTHESIS
`define DFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define DFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFE_ASSERT_IMP(lbl, ante, cons, msg)
`define DFE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/dfe_pkg.sv
`timescale 1ns / 1ps

package dfe_pkg;

  localparam int DELAY_DEPTH  = 65536;  // power of two, at most 65536
  localparam int MAX_CHANNELS = 2;      // power of two
  localparam int POS_AW = $clog2(DELAY_DEPTH);
  localparam int CH_W   = $clog2(MAX_CHANNELS);
  localparam int RAM_AW = CH_W + POS_AW;

  localparam int MUL_AW = 32;
  localparam int MUL_BW = 18;
  localparam int PROD_W = MUL_AW + MUL_BW;

  localparam logic [15:0] DELAY_RESET    = 16'd24000;
  localparam logic [14:0] FEEDBACK_RESET = 15'd16384;
  localparam logic [15:0] DAMPING_RESET  = 16'd32768;
  localparam logic [1:0]  CHANNELS_RESET = 2'd2;
  localparam logic [15:0] Q15_ONE        = 16'h8000;

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_DAMPING  = 2'd2,
    REG_CHANNELS = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic        channel;
    logic [15:0] sample_in;
    logic        mod_present;
    logic [15:0] feedback_mod;
  } in_item_t;

  typedef struct packed {
    logic [15:0] echo_out;
    logic        out_channel;
  } out_item_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [RAM_AW-1:0] addr;
    logic [15:0]       wdata;
  } ram_req_t;

  // Saturate a signed 20-bit value to 16 bits.
  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    logic [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: src/dfe_delay_ram.sv
`timescale 1ns / 1ps

module dfe_delay_ram import dfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  ram_req_t    req,
  output logic [15:0] rdata,
  output logic        busy
);

  logic [15:0]       mem [2**RAM_AW];
  logic [RAM_AW-1:0] clr_addr;

  // Zeroing sweep, one word per cycle; restarts on clear.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// File: src/dfe_mul.sv
`timescale 1ns / 1ps

module dfe_mul import dfe_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic signed [PROD_W-1:0] prod
);

  // Shared signed multiplier, product registered.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

// File: src/damped_feedback_echo.sv
`timescale 1ns / 1ps
// An item is taken only while idle, so the next one waits until the last is through the
// accepting step, four shared multiplier passes, the echo step and the filter step; a
// full output register holds the filter step.
// Reset (rst, synchronous, active high) restores the registers to their defaults and
// starts a zeroing sweep of the whole delay RAM; a delay_samples write starts the same
// sweep. No item is taken during a sweep.

`include "damped_feedback_echo_assert.svh"

module damped_feedback_echo import dfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,  // delayed * gain
    ST_MUL2 = 7'b0000100,  // (delayed * gain) * (1 + mod)
    ST_ECHO = 7'b0001000,  // subtract, round, saturate
    ST_MUL3 = 7'b0010000,  // echo * damping
    ST_MUL4 = 7'b0100000,  // last * (1 - damping)
    ST_FILT = 7'b1000000   // round, write back, hand out
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [15:0] delay_samples;
  logic [14:0] feedback_gain;
  logic [15:0] damping;
  logic [1:0]  channel_count;

  // Per-item context.
  logic              ch_r;
  logic [15:0]       x_r;
  logic [15:0]       mtot_r;   // 32768 + mod, always fits unsigned 16 bits
  logic [15:0]       pos_r;
  logic              adv_r;
  logic [RAM_AW-1:0] addr_r;
  logic [15:0]       y_r;
  logic [33:0]       acc;

  logic [15:0] ring_position;
  logic [15:0] last_filtered [MAX_CHANNELS];

  logic        accept;
  logic        out_load;
  logic [15:0] pos_eff;
  logic [1:0]  cnt_eff;
  logic [15:0] d_eff;
  logic [15:0] f_val;

  ram_req_t    ram_req;
  logic [15:0] ram_rdata;
  logic        ram_busy;
  logic        ram_clear;

  logic                     mul_en;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [48:0] echo_sum;
  logic [34:0] filt_sum;

  assign in_ready  = (state == ST_IDLE) && !ram_busy;
  assign accept    = in_valid && in_ready;
  assign ram_clear = cfg_we && (cfg_index == REG_DELAY);
  assign out_load  = (state == ST_FILT) && (!out_valid || out_ready);

  // Position wraps to zero once it runs past the ring length.
  assign pos_eff = (ring_position > delay_samples) ? 16'd0 : ring_position;

  // Channel count of zero acts as one, three acts as two.
  always_comb begin
    case (channel_count)
      2'd0:    cnt_eff = 2'd1;
      2'd3:    cnt_eff = 2'd2;
      default: cnt_eff = channel_count;
    endcase
  end

  assign d_eff = (damping > Q15_ONE) ? Q15_ONE : damping;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= DELAY_RESET;
      feedback_gain <= FEEDBACK_RESET;
      damping       <= DAMPING_RESET;
      channel_count <= CHANNELS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY:    delay_samples <= cfg_data;
        REG_FEEDBACK: feedback_gain <= cfg_data[14:0];
        REG_DAMPING:  damping       <= cfg_data;
        REG_CHANNELS: channel_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // RAM: read on accept, write back the filtered value in the last step.
  always_comb begin
    ram_req       = '0;
    ram_req.rd_en = accept;
    ram_req.addr  = {in_item.channel, pos_eff[POS_AW-1:0]};
    if (state == ST_FILT) begin
      ram_req.wr_en = 1'b1;
      ram_req.addr  = addr_r;
      ram_req.wdata = f_val;
    end
  end

  dfe_delay_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .clear (ram_clear),
    .req   (ram_req),
    .rdata (ram_rdata),
    .busy  (ram_busy)
  );

  // Operand select for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_MUL1: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(signed'(ram_rdata));
        mul_b  = MUL_BW'({1'b0, feedback_gain});
      end
      ST_MUL2: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(signed'(prod[30:0]));
        mul_b  = MUL_BW'({1'b0, mtot_r});
      end
      ST_MUL3: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(signed'(y_r));
        mul_b  = MUL_BW'({1'b0, d_eff});
      end
      ST_MUL4: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(signed'(last_filtered[ch_r]));
        mul_b  = MUL_BW'({1'b0, Q15_ONE - d_eff});
      end
      default: ;
    endcase
  end

  dfe_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // in * 2^30 - t + 2^29, then floor by 2^30: top bits of the sum.
  assign echo_sum = {{3{x_r[15]}}, x_r, 30'd0}
                  - {{2{prod[46]}}, prod[46:0]}
                  + 49'd536870912;

  // y*d + last*(1-d) + 2^14, then floor by 2^15.
  assign filt_sum = {acc[33], acc} + {prod[33], prod[33:0]} + 35'd16384;
  assign f_val    = sat16(signed'(filt_sum[34:15]));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_ECHO;
      ST_ECHO: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_MUL4;
      ST_MUL4: state_next = ST_FILT;
      // Holds here only while the output register is still full.
      ST_FILT: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item context and datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r   <= in_item.channel;
      x_r    <= in_item.sample_in;
      mtot_r <= in_item.mod_present
              ? {~in_item.feedback_mod[15], in_item.feedback_mod[14:0]} : Q15_ONE;
      pos_r  <= pos_eff;
      adv_r  <= ({1'b0, in_item.channel} == (cnt_eff - 2'd1));
      addr_r <= {in_item.channel, pos_eff[POS_AW-1:0]};
    end
    if (state == ST_ECHO) begin
      y_r <= sat16(signed'({echo_sum[48], echo_sum[48:30]}));
    end
    if (state == ST_MUL4) begin
      acc <= prod[33:0];
    end
  end

  // Per-channel filter memory, updated once per item, and ring position (last channel only).
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_position <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        last_filtered[i] <= '0;
      end
    end else if (out_load) begin
      last_filtered[ch_r] <= f_val;
      if (adv_r) begin
        ring_position <= pos_r + 16'd1;
      end
    end
  end

  // Output register: frees the sequencer while a result waits downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.echo_out    <= y_r;
      out_item.out_channel <= ch_r;
    end
  end

  `DFE_ASSERT_NXT(a_one_item, accept, !in_ready, "second item taken while busy")
  `DFE_ASSERT_IMP(a_sweep_block, ram_busy, !in_ready, "item taken during RAM sweep")
  `DFE_ASSERT_IMP(a_wr_sweep, ram_req.wr_en, !ram_busy, "RAM write during sweep")
  `DFE_ASSERT_NXT(a_delay_clear, ram_clear, ram_busy && !in_ready,
                  "delay write did not start sweep")

endmodule

// File: verif/damped_feedback_echo_test.sv
`timescale 1ns / 1ps

// Self-checking bench for damped_feedback_echo.
// Items go in through a valid/ready sender with random gaps; results come out
// against a receiver with random stalls. Every accepted item runs through a
// local echo predictor (delay ring, feedback gain, one-pole damping) and the
// expected result is queued; each result coming out is checked field by field
// against the oldest entry in that queue.

module damped_feedback_echo_test;
  import dfe_pkg::*;

  // No accepted item and no result taken for this many cycles means the block is
  // hung. It covers a full RAM clearing sweep with a wide margin.
  localparam int STALL_LIMIT = 524288;
  // Receiver hold-off: starts once this many items are in, lasts this long.
  localparam int SQUEEZE_AT  = 120;
  localparam int SQUEEZE_LEN = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  damped_feedback_echo dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Echo predictor state: registers, ring position, delay words, last outputs.
  // ---------------------------------------------------------------------------
  int unsigned dly_len  = DELAY_RESET;
  int unsigned fb_gain  = FEEDBACK_RESET;
  int unsigned damp     = DAMPING_RESET;
  int unsigned ch_count = CHANNELS_RESET;
  int unsigned ring_pos = 0;
  // Sparse delay store keyed by channel * DELAY_DEPTH + position.
  // A missing key reads as zero, which matches a freshly cleared RAM.
  logic signed [15:0] echo_mem [int unsigned];
  logic signed [15:0] last_f [MAX_CHANNELS] = '{default: '0};

  out_item_t echo_q [$];   // expected results, oldest first
  int        mismatches = 0;
  int        in_count = 0;
  bit        steady = 1'b0; // both sides run without gaps while set

  function automatic longint clip16(input longint v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic void apply_reg(input reg_index_t idx, input logic [15:0] val);
    case (idx)
      REG_DELAY: begin
        // A delay write also clears the whole store; ring position is kept.
        dly_len = val;
        echo_mem.delete();
      end
      REG_FEEDBACK: fb_gain = val[14:0];
      REG_DAMPING:  damp = val;
      REG_CHANNELS: ch_count = val[1:0];
      default: ;
    endcase
  endfunction

  // One sample through the echo: feedback subtract, saturate, damp, store back.
  function automatic out_item_t predict_echo(input in_item_t it);
    longint      smp, gmod, dly, prod, y, d, f;
    int unsigned ch, cnt, pos, key;
    out_item_t   r;
    ch   = it.channel % MAX_CHANNELS;
    smp  = longint'($signed(it.sample_in));
    gmod = it.mod_present ? longint'($signed(it.feedback_mod)) : 0;
    // count of zero acts as one, three acts as two
    cnt  = (ch_count == 0) ? 1 : (ch_count > 2) ? 2 : ch_count;
    // position past the ring end (e.g. after shrinking the delay) wraps to 0
    pos  = (ring_pos > dly_len) ? 0 : ring_pos;
    key  = ch * DELAY_DEPTH + pos % DELAY_DEPTH;
    dly  = echo_mem.exists(key) ? longint'(echo_mem[key]) : 0;
    // Q45 product: delayed * gain * (1 + mod)
    prod = dly * longint'(fb_gain) * (32768 + gmod);
    y    = clip16((smp * 1073741824 - prod + 536870912) >>> 30);
    // damping above unity behaves as no damping
    d    = (damp > 32768) ? 32768 : longint'(damp);
    f    = clip16((y * d + longint'(last_f[ch]) * (32768 - d) + 16384) >>> 15);
    echo_mem[key] = f[15:0];
    last_f[ch]    = f[15:0];
    // only the last channel of a frame moves the ring on
    if (it.channel == cnt - 1) ring_pos = (pos + 1) & 32'hFFFF;
    r.echo_out    = y[15:0];
    r.out_channel = it.channel;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] pick16();
    if ($urandom_range(5) == 0) begin
      case ($urandom_range(3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    if ($urandom_range(3) == 0) return 16'($urandom_range(2047) - 1024);
    return 16'($urandom);
  endfunction

  function automatic in_item_t make_item(input logic ch);
    in_item_t it;
    it.channel      = ch;
    it.sample_in    = pick16();
    it.mod_present  = 1'($urandom_range(1));
    it.feedback_mod = pick16();
    return it;
  endfunction

  // Offer one item; returns on the edge that accepts it. Valid stays up while
  // waiting; gaps are only inserted before raising it.
  task automatic offer(input in_item_t it);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly well-formed frames (0,1,0,1.. or 0,0,..) with an odd channel mixed in.
  task automatic play_frames(input int n, input int frame_len);
    int       slot;
    in_item_t it;
    slot = 0;
    repeat (n) begin
      it = make_item(($urandom_range(9) == 0) ? 1'($urandom_range(1)) : 1'(slot));
      slot = (slot + 1) % frame_len;
      offer(it);
      echo_q.push_back(predict_echo(it));
    end
    in_valid <= 1'b0;
  endtask

  // Wait until every expected result is back, then let the pipeline go quiet.
  task automatic settle();
    while (echo_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Registers go in index order, one per edge; the delay write is optional
  // since each one costs a full RAM clearing sweep.
  task automatic program_regs(input bit set_dly, input logic [15:0] dly,
                              input logic [15:0] fb, input logic [15:0] dmp,
                              input logic [15:0] cnt);
    logic [15:0] vals [4];
    vals = '{dly, fb, dmp, cnt};
    for (int i = (set_dly ? 0 : 1); i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_index_t'(i);
      cfg_data  <= vals[i];
      apply_reg(reg_index_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Directed items, all at reset settings. The store is clear and the ring is
  // far from wrapping, so the echo is just the input sample. The one row left
  // untyped revisits channel 0 at the same ring slot and reads its own echo.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic        ch;
    logic [15:0] smp;
    logic        mp;
    logic [15:0] mod;
    bit          typed;
    logic [15:0] want;
  } probe_row_t;

  probe_row_t probe_rows [17] = '{
    '{1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0000},
    '{1'b1, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0000},
    '{1'b0, 16'h7FFF, 1'b0, 16'h0000, 1'b1, 16'h7FFF},  // positive full scale
    '{1'b1, 16'h8000, 1'b0, 16'h0000, 1'b1, 16'h8000},  // negative full scale
    '{1'b0, 16'h8000, 1'b1, 16'h8000, 1'b1, 16'h8000},  // mod = -1: gain zero
    '{1'b1, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1, 16'h7FFF},  // mod near +1: gain x2
    '{1'b0, 16'hFFFF, 1'b1, 16'h0000, 1'b1, 16'hFFFF},
    '{1'b1, 16'h0001, 1'b1, 16'hFFFF, 1'b1, 16'h0001},
    '{1'b0, 16'h1234, 1'b1, 16'h8000, 1'b1, 16'h1234},
    '{1'b0, 16'hEDCB, 1'b0, 16'h7FFF, 1'b0, 16'h0000},  // same slot again
    '{1'b1, 16'h5555, 1'b1, 16'hAAAA, 1'b1, 16'h5555},
    '{1'b1, 16'hAAAA, 1'b0, 16'h5555, 1'b1, 16'hAAAA},  // repeated last channel
    '{1'b0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1, 16'h7FFF},
    '{1'b1, 16'h8000, 1'b1, 16'h8000, 1'b1, 16'h8000},
    '{1'b1, 16'h7FFF, 1'b1, 16'h0001, 1'b1, 16'h7FFF},
    '{1'b0, 16'h8000, 1'b0, 16'hFFFF, 1'b1, 16'h8000},
    '{1'b1, 16'h0100, 1'b1, 16'hC000, 1'b1, 16'h0100}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t  it;
    out_item_t exp_r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i]) begin
      it.channel      = probe_rows[i].ch;
      it.sample_in    = probe_rows[i].smp;
      it.mod_present  = probe_rows[i].mp;
      it.feedback_mod = probe_rows[i].mod;
      offer(it);
      exp_r = predict_echo(it);
      if (probe_rows[i].typed) exp_r.echo_out = probe_rows[i].want;
      echo_q.push_back(exp_r);
    end
    in_valid <= 1'b0;
    settle();

    // Short ring, full gain: heavy feedback and saturation. The ring position
    // left over from above exceeds the new length, so it restarts at 0.
    program_regs(1'b1, 16'd3, 16'd32767, DAMPING_RESET, 16'd2);
    play_frames(220, 2);
    settle();

    // Mono, zero gain, full damping (filter holds its last value).
    program_regs(1'b0, 16'd0, 16'd0, 16'd0, 16'd1);
    play_frames(100, 1);
    settle();

    // Single-slot ring, damping past unity, channel count zero.
    program_regs(1'b1, 16'd0, 16'd20000, 16'd40000, 16'd0);
    play_frames(150, 1);
    settle();

    // Channel count three, partial damping, no gaps on either side.
    program_regs(1'b0, 16'd0, 16'($urandom_range(32767)), 16'd12345, 16'd3);
    steady = 1'b1;
    play_frames(200, 2);
    steady = 1'b0;
    settle();

    // Longest ring and largest damping code.
    program_regs(1'b1, 16'hFFFF, 16'd16384, 16'hFFFF, 16'd2);
    play_frames(100, 2);
    settle();

    // Random short ring and random gain/damping for the bulk.
    program_regs(1'b1, 16'($urandom_range(9, 1)), 16'($urandom_range(32767)),
                 16'($urandom_range(32768)), 16'd2);
    play_frames(363, 2);
    settle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off so the block backs up and
  // drops in_ready while the sender keeps offering.
  // ---------------------------------------------------------------------------
  int  squeeze_left = 0;
  bit  squeezed = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (squeeze_left != 0) begin
      out_ready    <= 1'b0;
      squeeze_left <= squeeze_left - 1;
    end else if (!squeezed && in_count >= SQUEEZE_AT) begin
      squeezed     <= 1'b1;
      squeeze_left <= SQUEEZE_LEN;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 38);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (echo_q.size() == 0) begin
        report_mismatch("unexpected item", out_item.echo_out, 16'h0000);
      end else begin
        want = echo_q.pop_front();
        if (out_item.echo_out !== want.echo_out)
          report_mismatch("echo_out", out_item.echo_out, want.echo_out);
        if (out_item.out_channel !== want.out_channel)
          report_mismatch("out_channel", 16'(out_item.out_channel),
                          16'(want.out_channel));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Accepted-item count and hang watchdog
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (in_valid && in_ready) in_count <= in_count + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: files.f
+incdir+src
src/dfe_pkg.sv
src/dfe_delay_ram.sv
src/dfe_mul.sv
src/damped_feedback_echo.sv
verif/damped_feedback_echo_test.sv
